/* rtl/mtel_pkg.sv */
// ----------------------------------------------------------------------------
// Move-to-end list cipher package
// Shared widths and default sizing for the list cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtel_pkg;

  // Width of one message symbol
  localparam int unsigned SymW = 8;

  // Default number of list entries (one per distinct byte value)
  localparam int unsigned ListDepthDefault = 256;

  // Mode register codes
  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_e;

endpackage : mtel_pkg

`default_nettype wire

/* rtl/mtel_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mtel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : mtel_ram

`default_nettype wire

/* rtl/move_to_end_list_cipher.sv */
// ----------------------------------------------------------------------------
// Move-to-end list cipher
// Byte stream cipher over an ordered list of the bytes seen in a message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one byte and a first flag;
//   a set first flag empties the list before the byte is handled. Output
//   channel (out_valid_o/out_ready_i) returns exactly one byte per request.
//   cfg_we_i/cfg_wdata_i write the mode (0 encrypt, 1 decrypt); write it
//   only while no request is in flight.
// Operation:
//   The list sits in a one-read, one-write RAM and a single compare unit
//   scans it, one entry per cycle. An unseen byte is searched for over the
//   whole list, appended if there is room and passed through. A byte found
//   in the list is followed by a fetch of the result entry; then the gap
//   behind the moved entry is closed, the moved byte is put last and the
//   result is handed to the output. One request at a time.
// Reset and stalls:
//   Reset empties the list and selects encrypt. The result waits in an
//   output register; the next request is accepted meanwhile, and its
//   result is held back until the receiver has taken the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_end_list_cipher #(
  parameter int unsigned ListDepth = mtel_pkg::ListDepthDefault
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration
  input  wire                        cfg_we_i,
  input  wire                        cfg_wdata_i,
  // input requests
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [mtel_pkg::SymW-1:0]   symbol_in_i,
  input  wire                        first_i,
  // results
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [mtel_pkg::SymW-1:0]  symbol_out_o
);

  import mtel_pkg::*;

  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FWAIT,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pidx_q, pidx_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   mv_q, mv_d;
  logic [CW-1:0]   wk_q, wk_d;
  logic [SymW-1:0] sym_q, sym_d;
  logic [SymW-1:0] res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic [SymW-1:0] out_data_q, out_data_d;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [SymW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [SymW-1:0] ram_rdata;

  // Index arithmetic
  logic            hit;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   pidx_p1;
  logic [CW-1:0]   res_idx;
  logic [CW-1:0]   mv_idx;
  logic [CW-1:0]   mv_p1;
  logic [CW-1:0]   wk_p2;

  mtel_ram #(
    .Width (SymW),
    .Depth (ListDepth)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared compare and index unit
  always_comb begin
    hit      = pend_q && (ram_rdata == sym_q);
    count_m1 = count_q - CW'(1);
    pidx_p1  = pidx_q + CW'(1);
    mv_p1    = mv_q + CW'(1);
    wk_p2    = wk_q + CW'(2);
    if (mode_q == MODE_ENCRYPT) begin
      // predecessor (cyclic) is the result, the found entry moves
      res_idx = (pidx_q == '0) ? count_m1 : pidx_q - CW'(1);
      mv_idx  = pidx_q;
    end else begin
      // successor (cyclic) is the result and also the entry that moves
      res_idx = (pidx_p1 == count_q) ? '0 : pidx_p1;
      mv_idx  = res_idx;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    mv_d        = mv_q;
    wk_d        = wk_q;
    sym_d       = sym_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = sym_q;
    ram_raddr   = idx_q[AW-1:0];

    if (cfg_we_i) begin
      mode_d = mode_e'(cfg_wdata_i);
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sym_d   = symbol_in_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          if (first_i) begin
            count_d = '0;
          end
          state_d = ST_SEARCH;
        end
      end

      // Scan entries in order; read data is registered and trails the read address by one entry
      ST_SEARCH: begin
        if (hit) begin
          ram_raddr = res_idx[AW-1:0];
          mv_d      = mv_idx;
          state_d   = ST_FWAIT;
        end else if (idx_q == count_q) begin
          // not in the list: append if there is room, pass through
          res_d = sym_q;
          if (count_q < CW'(ListDepth)) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = sym_q;
            count_d   = count_q + CW'(1);
          end
          state_d = ST_DONE;
        end else begin
          ram_raddr = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
          pidx_d    = idx_q;
          pend_d    = 1'b1;
        end
      end

      // Result entry arrives; start reading behind the moved entry
      ST_FWAIT: begin
        res_d     = ram_rdata;
        wk_d      = mv_q;
        ram_raddr = mv_p1[AW-1:0];
        state_d   = ST_SHIFT;
      end

      // Close the gap one entry per cycle, then put the moved byte last
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wk_q[AW-1:0];
        if (wk_q == count_m1) begin
          ram_wdata = (mode_q == MODE_ENCRYPT) ? sym_q : res_q;
          state_d   = ST_DONE;
        end else begin
          ram_wdata = ram_rdata;
          ram_raddr = wk_p2[AW-1:0];
          wk_d      = wk_q + CW'(1);
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_ENCRYPT;
      count_q     <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      mv_q        <= '0;
      wk_q        <= '0;
      sym_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pidx_q      <= pidx_d;
      pend_q      <= pend_d;
      mv_q        <= mv_d;
      wk_q        <= wk_d;
      sym_q       <= sym_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign symbol_out_o = out_data_q;

endmodule : move_to_end_list_cipher

`default_nettype wire
